@@ rtl/pcm_stream_rechunker_core_assert.svh @@
// Assertion macros used by the rechunker controller RTL.
// Each expects clk and rst_n in scope.
`ifndef PCM_STREAM_RECHUNKER_CORE_ASSERT_SVH
`define PCM_STREAM_RECHUNKER_CORE_ASSERT_SVH

// same-cycle implication
`define PCMRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCMRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pcmrc_pkg.sv @@
`default_nettype none
package pcmrc_pkg;

  localparam int MAX_CHUNK_SAMPLES_DEF = 65536;
  localparam int MAX_FRAME_BYTES_DEF   = 64;

  // APB register map
  localparam int CFG_AW = 5;
  localparam logic [2:0] REG_CHUNK_SAMPLES   = 3'd0;
  localparam logic [2:0] REG_FRAME_RATE_NUM  = 3'd1;
  localparam logic [2:0] REG_FRAME_RATE_DEN  = 3'd2;
  localparam logic [2:0] REG_PCM_RATE        = 3'd3;
  localparam logic [2:0] REG_BYTES_PER_FRAME = 3'd4;
  localparam logic [2:0] REG_PAD_ENABLE      = 3'd5;
  localparam logic [2:0] REG_SILENCE_BYTE    = 3'd6;

  localparam logic [16:0] RST_CHUNK_SAMPLES   = 17'd1024;
  localparam logic [15:0] RST_FRAME_RATE_NUM  = 16'd0;
  localparam logic [15:0] RST_FRAME_RATE_DEN  = 16'd1;
  localparam logic [19:0] RST_PCM_RATE        = 20'd48000;
  localparam logic [6:0]  RST_BYTES_PER_FRAME = 7'd4;
  localparam logic        RST_PAD_ENABLE      = 1'b1;
  localparam logic [7:0]  RST_SILENCE_BYTE    = 8'd0;

  // item kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EOS   = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;

  // shared divider: widest dividend is 2*k*r + num (49 bits), divisor 2*num
  localparam int DIV_DW = 49;
  localparam int DIV_VW = 17;

  typedef struct packed {
    logic accept;
    logic q_start;
    logic q_take;
    logic mult;
    logic r_start;
    logic r_take;
    logic tgt;
    logic cbytes;
    logic cut_start;
    logic cut_emit;
  } cmd_t;

  typedef struct packed {
    logic ev_recompute;
    logic ev_cut;
    logic bytes_zero;
    logic fixed_mode;
    logic div_done;
    logic cfg_wr;
    logic out_busy;
    logic out_valid;
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/pcmrc_in_if.sv @@
`default_nettype none
interface pcmrc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink   (input valid, kind, data_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/pcmrc_out_if.sv @@
`default_nettype none
interface pcmrc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [22:0] run_length;
  logic        chunk_end;
  logic [16:0] chunk_frames;
  logic        discarded;

  modport source (output valid, out_byte, run_length, chunk_end, chunk_frames, discarded,
                  input ready);
  modport sink   (input valid, out_byte, run_length, chunk_end, chunk_frames, discarded,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/pcmrc_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle. start reloads at any time.
module pcmrc_div #(
  parameter int DW = 49,
  parameter int VW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quot,
  output logic [VW-1:0]      rem
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r, d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [VW:0]   sh, diff;
  logic          ge;

  always_comb begin
    sh   = {rem_r, q_r[DW-1]};
    diff = sh - {1'b0, d_r};
    ge   = sh >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DW-2:0], ge};
      rem_r <= ge ? diff[VW-1:0] : sh[VW-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

@@ rtl/pcmrc_dp.sv @@
`default_nettype none
module pcmrc_dp #(
  parameter int MAX_CHUNK_SAMPLES = pcmrc_pkg::MAX_CHUNK_SAMPLES_DEF,
  parameter int MAX_FRAME_BYTES   = pcmrc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire pcmrc_pkg::cmd_t             cmd,
  output pcmrc_pkg::stat_t                 stat,
  input  wire logic [1:0]                  in_kind,
  input  wire logic [7:0]                  in_data_byte,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [7:0]                       out_byte,
  output logic [22:0]                      out_run_length,
  output logic                             out_chunk_end,
  output logic [16:0]                      out_chunk_frames,
  output logic                             out_discarded,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pcmrc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import pcmrc_pkg::*;

  localparam int TW  = $clog2(MAX_CHUNK_SAMPLES + 1);
  localparam int BW  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CBW = TW + BW;
  localparam int FW  = (CBW > 23) ? CBW : 23;

  // configuration
  logic [16:0] chunk_samples_r;
  logic [15:0] frame_rate_num_r, frame_rate_den_r;
  logic [19:0] pcm_rate_r;
  logic [6:0]  bytes_per_frame_r;
  logic        pad_enable_r;
  logic [7:0]  silence_byte_r;

  logic [2:0] reg_idx;
  logic       wr_en, cfg_hit;

  // chunk state
  logic [31:0]     idx_r, idx_nxt;
  logic [22:0]     bytes_r, bytes_nxt;
  logic [TW-1:0]   target_r;
  logic [CBW-1:0]  cbytes_r;
  logic [35:0]     q_r;
  logic [15:0]     r_r;
  logic [DIV_DW-1:0] x_r;
  logic [DIV_VW-1:0] rem_r;
  logic [47:0]     kr_prod;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic [22:0] rl_r, rl_nxt;
  logic        ce_r, ce_nxt;
  logic [16:0] cf_r, cf_nxt;
  logic        dc_r, dc_nxt;
  logic        load;

  logic [8:0]    bpf_w;
  logic [BW-1:0] bpf;
  logic [22:0]   bytes_inc;
  logic          complete, open, ev_pad;
  logic [22:0]   fill;
  logic [17:0]   carry_sum;
  logic          carry;
  logic [36:0]   t_raw;
  logic [TW-1:0] t_clamp;

  logic              div_start, div_done;
  logic [DIV_DW-1:0] div_dividend, div_quot;
  logic [DIV_VW-1:0] div_divisor, div_rem;

  // APB decode
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      REG_CHUNK_SAMPLES, REG_FRAME_RATE_NUM, REG_FRAME_RATE_DEN, REG_PCM_RATE,
      REG_BYTES_PER_FRAME, REG_PAD_ENABLE, REG_SILENCE_BYTE: cfg_hit = wr_en;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (reg_idx)
      REG_CHUNK_SAMPLES:   prdata = 32'(chunk_samples_r);
      REG_FRAME_RATE_NUM:  prdata = 32'(frame_rate_num_r);
      REG_FRAME_RATE_DEN:  prdata = 32'(frame_rate_den_r);
      REG_PCM_RATE:        prdata = 32'(pcm_rate_r);
      REG_BYTES_PER_FRAME: prdata = 32'(bytes_per_frame_r);
      REG_PAD_ENABLE:      prdata = 32'(pad_enable_r);
      REG_SILENCE_BYTE:    prdata = 32'(silence_byte_r);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_samples_r   <= RST_CHUNK_SAMPLES;
      frame_rate_num_r  <= RST_FRAME_RATE_NUM;
      frame_rate_den_r  <= RST_FRAME_RATE_DEN;
      pcm_rate_r        <= RST_PCM_RATE;
      bytes_per_frame_r <= RST_BYTES_PER_FRAME;
      pad_enable_r      <= RST_PAD_ENABLE;
      silence_byte_r    <= RST_SILENCE_BYTE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CHUNK_SAMPLES:   chunk_samples_r   <= pwdata[16:0];
        REG_FRAME_RATE_NUM:  frame_rate_num_r  <= pwdata[15:0];
        REG_FRAME_RATE_DEN:  frame_rate_den_r  <= pwdata[15:0];
        REG_PCM_RATE:        pcm_rate_r        <= pwdata[19:0];
        REG_BYTES_PER_FRAME: bytes_per_frame_r <= pwdata[6:0];
        REG_PAD_ENABLE:      pad_enable_r      <= pwdata[0];
        REG_SILENCE_BYTE:    silence_byte_r    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // frame size clamped to 1..MAX_FRAME_BYTES
  always_comb begin
    bpf_w = (bytes_per_frame_r == 7'd0) ? 9'd1 : {2'b00, bytes_per_frame_r};
    if (bpf_w > 9'(MAX_FRAME_BYTES)) bpf_w = 9'(MAX_FRAME_BYTES);
    bpf = BW'(bpf_w);
  end

  // item events
  always_comb begin
    bytes_inc = bytes_r + 23'd1;
    complete  = FW'(bytes_inc) >= FW'(cbytes_r);
    open      = bytes_r != 23'd0;
    ev_pad    = (in_kind == KIND_EOS) && open && pad_enable_r;
    fill      = (FW'(cbytes_r) > FW'(bytes_r)) ? 23'(FW'(cbytes_r) - FW'(bytes_r)) : 23'd0;
  end

  assign stat.ev_recompute = ((in_kind == KIND_DATA) && complete) || ev_pad ||
                             (in_kind == KIND_RESET);
  assign stat.ev_cut       = (in_kind == KIND_EOS) && open && !pad_enable_r;
  assign stat.bytes_zero   = !open;
  assign stat.fixed_mode   = frame_rate_num_r == 16'd0;
  assign stat.div_done     = div_done;
  assign stat.cfg_wr       = cfg_hit;
  assign stat.out_busy     = out_valid_r & !out_ready;
  assign stat.out_valid    = out_valid_r;

  // target: chunk_samples, or q + fractional carry; clamped to 1..MAX
  always_comb begin
    carry_sum = {1'b0, rem_r} + {1'b0, r_r, 1'b0};
    carry     = carry_sum >= {1'b0, frame_rate_num_r, 1'b0};
    if (stat.fixed_mode) t_raw = 37'(chunk_samples_r);
    else                 t_raw = 37'(q_r) + 37'(carry);
    if (t_raw > 37'(MAX_CHUNK_SAMPLES)) t_clamp = TW'(MAX_CHUNK_SAMPLES);
    else if (t_raw == 37'd0)            t_clamp = TW'(1);
    else                                t_clamp = TW'(t_raw);
  end

  // shared divider operands
  always_comb begin
    div_start = cmd.q_start | cmd.r_start | cmd.cut_start;
    if (cmd.q_start) begin
      div_dividend = DIV_DW'(pcm_rate_r * frame_rate_den_r);
      div_divisor  = DIV_VW'(frame_rate_num_r);
    end else if (cmd.r_start) begin
      div_dividend = x_r;
      div_divisor  = {frame_rate_num_r, 1'b0};
    end else begin
      div_dividend = DIV_DW'(bytes_r);
      div_divisor  = DIV_VW'(bpf);
    end
  end

  pcmrc_div #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // k*r, 32x16
  assign kr_prod = 48'(idx_r * r_r);

  // chunk bookkeeping and result load
  always_comb begin
    idx_nxt   = idx_r;
    bytes_nxt = bytes_r;
    load      = 1'b0;
    ob_nxt    = '0;
    rl_nxt    = '0;
    ce_nxt    = 1'b0;
    cf_nxt    = '0;
    dc_nxt    = 1'b0;
    if (cmd.accept) begin
      case (in_kind)
        KIND_DATA: begin
          load   = 1'b1;
          ob_nxt = in_data_byte;
          rl_nxt = 23'd1;
          if (complete) begin
            ce_nxt    = 1'b1;
            cf_nxt    = 17'(target_r);
            idx_nxt   = idx_r + 32'd1;
            bytes_nxt = '0;
          end else begin
            bytes_nxt = bytes_inc;
          end
        end
        KIND_EOS: begin
          if (ev_pad) begin
            load      = 1'b1;
            ob_nxt    = silence_byte_r;
            rl_nxt    = fill;
            ce_nxt    = 1'b1;
            cf_nxt    = 17'(target_r);
            idx_nxt   = idx_r + 32'd1;
            bytes_nxt = '0;
          end
        end
        KIND_RESET: begin
          load      = open;
          dc_nxt    = 1'b1;
          idx_nxt   = '0;
          bytes_nxt = '0;
        end
        default: ;
      endcase
    end else if (cmd.cut_emit) begin
      load      = 1'b1;
      ce_nxt    = 1'b1;
      cf_nxt    = 17'(div_quot);
      idx_nxt   = idx_r + 32'd1;
      bytes_nxt = '0;
    end
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      bytes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      bytes_r     <= bytes_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_r <= ob_nxt;
      rl_r <= rl_nxt;
      ce_r <= ce_nxt;
      cf_r <= cf_nxt;
      dc_r <= dc_nxt;
    end
    if (cmd.q_take) begin
      q_r <= div_quot[35:0];
      r_r <= div_rem[15:0];
    end
    if (cmd.mult)   x_r      <= {kr_prod, 1'b0} + DIV_DW'(frame_rate_num_r);
    if (cmd.r_take) rem_r    <= div_rem;
    if (cmd.tgt)    target_r <= t_clamp;
    if (cmd.cbytes) cbytes_r <= CBW'(target_r * bpf);
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = ob_r;
  assign out_run_length   = rl_r;
  assign out_chunk_end    = ce_r;
  assign out_chunk_frames = cf_r;
  assign out_discarded    = dc_r;
endmodule
`default_nettype wire

@@ rtl/pcmrc_ctrl.sv @@
`default_nettype none
`include "pcm_stream_rechunker_core_assert.svh"
module pcmrc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pcmrc_pkg::stat_t stat,
  output pcmrc_pkg::cmd_t       cmd
);
  import pcmrc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_QGO    = 9'b000000010,
    S_QDIV   = 9'b000000100,
    S_MULT   = 9'b000001000,
    S_RGO    = 9'b000010000,
    S_RDIV   = 9'b000100000,
    S_TGT    = 9'b001000000,
    S_CBYTES = 9'b010000000,
    S_CUT    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE) && !stat.out_busy && !stat.cfg_wr;
  assign accept   = in_valid & in_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.accept    = accept;
    cmd.cut_start = accept & stat.ev_cut;
    case (state_r)
      S_IDLE: begin
        if (accept && stat.ev_recompute) state_nxt = S_QGO;
        else if (accept && stat.ev_cut)  state_nxt = S_CUT;
      end
      S_QGO: begin
        if (stat.fixed_mode) begin
          state_nxt = S_TGT;
        end else begin
          cmd.q_start = 1'b1;
          state_nxt   = S_QDIV;
        end
      end
      S_QDIV: begin
        if (stat.div_done) begin
          cmd.q_take = 1'b1;
          state_nxt  = S_MULT;
        end
      end
      S_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = S_RGO;
      end
      S_RGO: begin
        cmd.r_start = 1'b1;
        state_nxt   = S_RDIV;
      end
      S_RDIV: begin
        if (stat.div_done) begin
          cmd.r_take = 1'b1;
          state_nxt  = S_TGT;
        end
      end
      S_TGT: begin
        cmd.tgt   = 1'b1;
        state_nxt = S_CBYTES;
      end
      S_CBYTES: begin
        cmd.cbytes = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_CUT: begin
        if (stat.div_done) begin
          cmd.cut_emit = 1'b1;
          state_nxt    = S_QGO;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // register write: redo the target if no chunk is open, else just the byte count
    if (stat.cfg_wr && state_r != S_CUT) begin
      state_nxt = stat.bytes_zero ? S_QGO : S_CBYTES;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_QGO;
    else        state_r <= state_nxt;
  end

  `PCMRC_ASSERT_NEXT(a_cut_waits, accept && stat.ev_cut, state_r == S_CUT, "cut not started")
  `PCMRC_ASSERT_NEXT(a_cut_emits, state_r == S_CUT && stat.div_done, stat.out_valid,
                     "cut result lost")
  `PCMRC_ASSERT_NEXT(a_recompute_blocks, accept && stat.ev_recompute, !in_ready,
                     "input taken before target ready")
endmodule
`default_nettype wire

@@ rtl/pcm_stream_rechunker_core.sv @@
// A data, pad or discard word is presented the cycle after its input word is accepted.
// One word per cycle inside a chunk unless back-pressure or a register write holds
//   input; a chunk end or reset word stalls input while the target is recomputed, with
//   two divider passes in rate mode. A cut-short end's result waits on one division.
// Reset: synchronous active-low rst_n; registers return to defaults and the chunk 0
//   target is computed before the first word is taken.
`default_nettype none
module pcm_stream_rechunker_core #(
  parameter int MAX_CHUNK_SAMPLES = pcmrc_pkg::MAX_CHUNK_SAMPLES_DEF,
  parameter int MAX_FRAME_BYTES   = pcmrc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  pcmrc_in_if.sink                          in_ch,
  pcmrc_out_if.source                       out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pcmrc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import pcmrc_pkg::*;

  // controller sequences the target computation:
  //   q,r = pcm_rate*den / num           (shared divider)
  //   x   = 2*k*r + num                  (one multiply)
  //   rem = x mod 2*num                  (shared divider)
  //   target = q + (rem + 2r >= 2*num), clamped; then bytes = target * frame size
  // Fixed mode skips straight to the clamp.
  cmd_t  cmd;
  stat_t stat;

  pcmrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath holds registers, chunk counters, divider and the output word register
  pcmrc_dp #(
    .MAX_CHUNK_SAMPLES (MAX_CHUNK_SAMPLES),
    .MAX_FRAME_BYTES   (MAX_FRAME_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_ch.kind),
    .in_data_byte     (in_ch.data_byte),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_byte         (out_ch.out_byte),
    .out_run_length   (out_ch.run_length),
    .out_chunk_end    (out_ch.chunk_end),
    .out_chunk_frames (out_ch.chunk_frames),
    .out_discarded    (out_ch.discarded),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );
endmodule
`default_nettype wire

@@ tb/sv/pcm_stream_rechunker_core_tb.sv @@
`default_nettype none
module pcm_stream_rechunker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcmrc_pkg::*;

  // kind code that the block must ignore
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // cycles to let pass before a register write: one cut-short division
  // plus a full rate-mode chunk turnaround, with margin
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT   = 20000;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [22:0] run_length;
    logic        chunk_end;
    logic [16:0] chunk_frames;
    logic        discarded;
  } chunk_word_t;

  // Tracks the chunking state and holds the words the block owes us.
  class chunk_scoreboard;
    bit [16:0] chunk_samples;
    bit [15:0] rate_num, rate_den;
    bit [19:0] pcm_rate;
    bit [6:0]  frame_size;
    bit        pad_on;
    bit [7:0]  fill_byte;
    bit [31:0] chunk_idx;
    bit [22:0] bytes_held;
    bit [16:0] target;
    chunk_word_t owed[$];
    int errors;

    function new();
      chunk_samples = RST_CHUNK_SAMPLES;
      rate_num      = RST_FRAME_RATE_NUM;
      rate_den      = RST_FRAME_RATE_DEN;
      pcm_rate      = RST_PCM_RATE;
      frame_size    = RST_BYTES_PER_FRAME;
      pad_on        = RST_PAD_ENABLE;
      fill_byte     = RST_SILENCE_BYTE;
      chunk_idx     = 0;
      bytes_held    = 0;
      errors        = 0;
      target        = frames_for(0);
    endfunction

    function longint unsigned round_half(longint unsigned m, longint unsigned r,
                                         longint unsigned num);
      return (2 * m * r + num) / (2 * num);
    endfunction

    // frames in chunk k, rounded half up, clamped to 1..65536
    function bit [16:0] frames_for(bit [31:0] k);
      longint unsigned t, num, p, q, r, m;
      if (rate_num == 0) begin
        t = 64'(chunk_samples);
      end else begin
        num = 64'(rate_num);
        p = longint'(pcm_rate) * longint'(rate_den);
        q = p / num;
        r = p % num;
        m = 64'(k);
        t = q + round_half(m + 1, r, num) - round_half(m, r, num);
      end
      if (t > 64'(MAX_CHUNK_SAMPLES_DEF)) t = 64'(MAX_CHUNK_SAMPLES_DEF);
      if (t == 0) t = 1;
      return t[16:0];
    endfunction

    function bit [31:0] bytes_per_frame_used();
      bit [31:0] b;
      b = 32'(frame_size);
      if (b == 0) b = 1;
      if (b > MAX_FRAME_BYTES_DEF) b = MAX_FRAME_BYTES_DEF;
      return b;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_CHUNK_SAMPLES:   chunk_samples = v[16:0];
        REG_FRAME_RATE_NUM:  rate_num      = v[15:0];
        REG_FRAME_RATE_DEN:  rate_den      = v[15:0];
        REG_PCM_RATE:        pcm_rate      = v[19:0];
        REG_BYTES_PER_FRAME: frame_size    = v[6:0];
        REG_PAD_ENABLE:      pad_on        = v[0];
        REG_SILENCE_BYTE:    fill_byte     = v[7:0];
        default: return;
      endcase
      // a write only retargets when no chunk is open
      if (bytes_held == 0) target = frames_for(chunk_idx);
    endfunction

    function void start_next_chunk();
      chunk_idx  = chunk_idx + 32'd1;
      bytes_held = 0;
      target     = frames_for(chunk_idx);
    endfunction

    function void note_word(logic [1:0] kind, logic [7:0] data);
      bit [31:0] bpf, chunk_bytes;
      chunk_word_t w;
      bit open;
      bpf = bytes_per_frame_used();
      chunk_bytes = 32'(target) * bpf;
      w = '0;
      case (kind)
        KIND_DATA: begin
          bytes_held = bytes_held + 23'd1;
          w.out_byte = data;
          w.run_length = 23'd1;
          if (32'(bytes_held) >= chunk_bytes) begin
            w.chunk_end = 1;
            w.chunk_frames = target;
            start_next_chunk();
          end
          owed.push_back(w);
        end
        KIND_EOS: begin
          if (bytes_held != 0) begin
            w.chunk_end = 1;
            if (pad_on) begin
              w.out_byte = fill_byte;
              w.run_length = (chunk_bytes > 32'(bytes_held)) ?
                             23'(chunk_bytes - 32'(bytes_held)) : 23'd0;
              w.chunk_frames = target;
            end else begin
              w.chunk_frames = 17'(32'(bytes_held) / bpf);
            end
            owed.push_back(w);
            start_next_chunk();
          end
        end
        KIND_RESET: begin
          open = bytes_held != 0;
          chunk_idx  = 0;
          bytes_held = 0;
          target     = frames_for(0);
          if (open) begin
            w.discarded = 1;
            owed.push_back(w);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_word(chunk_word_t got);
      chunk_word_t want;
      if (owed.size() == 0) begin
        $error("unexpected result word %p", got);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0d, got %0d", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.run_length !== want.run_length) begin
        $error("run_length: expected %0d, got %0d", want.run_length, got.run_length);
        errors++;
      end
      if (got.chunk_end !== want.chunk_end) begin
        $error("chunk_end: expected %0d, got %0d", want.chunk_end, got.chunk_end);
        errors++;
      end
      if (got.chunk_frames !== want.chunk_frames) begin
        $error("chunk_frames: expected %0d, got %0d", want.chunk_frames, got.chunk_frames);
        errors++;
      end
      if (got.discarded !== want.discarded) begin
        $error("discarded: expected %0d, got %0d", want.discarded, got.discarded);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  pcmrc_in_if  in_ch();
  pcmrc_out_if out_ch();

  pcm_stream_rechunker_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  chunk_scoreboard sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // receiver: random backpressure per the current idle profile
  initial out_ch.ready = 0;
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitors: words and register writes are taken at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (psel && penable && pwrite && pready)
        sb.write_reg(3'(paddr >> 2), pwdata);
      if (in_ch.valid && in_ch.ready)
        sb.note_word(in_ch.kind, in_ch.data_byte);
      if (out_ch.valid && out_ch.ready)
        sb.check_word({out_ch.out_byte, out_ch.run_length, out_ch.chunk_end,
                       out_ch.chunk_frames, out_ch.discarded});
    end
  end

  // watchdog: too long with no word or APB access taken anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_word(logic [1:0] kind, logic [7:0] data);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_ch.valid     <= 1;
    in_ch.kind      <= kind;
    in_ch.data_byte <= data;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_ch.valid <= 0;
  endtask

  // hold off until every owed word has come out, then let the block settle
  task automatic drain();
    drop_valid();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= CFG_AW'(idx) << 2;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel    <= 0;
    penable <= 0;
  endtask

  task automatic load_setup(logic [31:0] cs, logic [31:0] num, logic [31:0] den,
                            logic [31:0] sr, logic [31:0] bpf, logic [31:0] pad,
                            logic [31:0] sil);
    apb_write(REG_CHUNK_SAMPLES, cs);
    apb_write(REG_FRAME_RATE_NUM, num);
    apb_write(REG_FRAME_RATE_DEN, den);
    apb_write(REG_PCM_RATE, sr);
    apb_write(REG_BYTES_PER_FRAME, bpf);
    apb_write(REG_PAD_ENABLE, pad);
    apb_write(REG_SILENCE_BYTE, sil);
  endtask

  // mostly data runs, sprinkled with end-of-stream, restart and junk kinds
  task automatic random_words(int n, int eos_pct);
    int sent, roll;
    sent = 0;
    while (sent < n) begin
      roll = $urandom_range(99);
      if (roll < eos_pct) begin
        send_word(KIND_EOS, 8'($urandom));
      end else if (roll < eos_pct + 2) begin
        send_word(KIND_RESET, 8'($urandom));
      end else if (roll < eos_pct + 3) begin
        send_word(KIND_UNUSED, 8'($urandom));
        continue;
      end else begin
        send_word(KIND_DATA, 8'($urandom));
      end
      sent++;
    end
  endtask

  initial begin
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.kind = KIND_DATA;
    in_ch.data_byte = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    stall_cycles = 0;
    send_idle_pct = 18;
    recv_idle_pct = 83;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: two one-byte frames per chunk, padded with the a-law fill
    load_setup(2, 0, 1, 48000, 1, 1, 8'hd5);
    send_word(KIND_DATA, 8'h00);
    send_word(KIND_DATA, 8'hff);      // fills chunk 0
    send_word(KIND_EOS, 8'h00);       // nothing open: silent
    send_word(KIND_DATA, 8'haa);
    send_word(KIND_EOS, 8'h00);       // pad one byte
    send_word(KIND_DATA, 8'h55);
    send_word(KIND_RESET, 8'h00);     // open chunk is discarded
    send_word(KIND_RESET, 8'h00);     // nothing open: silent
    send_word(KIND_UNUSED, 8'h12);    // ignored
    drain();
    // cut-short close with a wide frame
    apb_write(REG_PAD_ENABLE, 0);
    apb_write(REG_BYTES_PER_FRAME, 3);
    repeat (7) send_word(KIND_DATA, 8'($urandom));
    send_word(KIND_EOS, 8'h00);
    drain();
    // largest chunk, largest frame, padded with a huge silence run
    load_setup(65536, 0, 1, 48000, 64, 1, 8'hff);
    repeat (3) send_word(KIND_DATA, 8'($urandom));
    send_word(KIND_EOS, 8'h00);
    drain();

    // random phases across several settings
    load_setup(3, 0, 1, 48000, 2, 1, 8'hff);
    random_words(160, 4);
    drain();
    load_setup(1, 0, 1, 48000, 1, 0, 8'h80);
    random_words(150, 4);
    drain();
    load_setup(1024, 9600, 1, 48000, 2, 1, 8'h80);   // five frames per chunk
    random_words(160, 4);
    drain();

    send_idle_pct = 83;
    recv_idle_pct = 18;
    load_setup(1024, 7000, 3, 11025, 1, 0, 8'h00);   // fractional rate
    random_words(150, 4);
    drain();
    // rate far below one chunk per frame: clamped at the top, frame size clamped
    load_setup(5, 65535, 65535, 20'hfffff, 7'h7f, 1, 8'hd5);
    random_words(140, 10);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_setup(0, 0, 1, 48000, 0, 1, 8'h00);         // zero sizes give one byte
    random_words(150, 4);
    drain();
    load_setup(7, 65535, 1, 1, 3, 1, 8'h5a);         // rate above sample rate
    random_words(150, 5);

    drain();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
